// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dq_pkg.sv -----
// ---------------------------------------------------------------------------
// dq_pkg
// request kinds, status codes and default sizes of the double-ended queue
// ---------------------------------------------------------------------------
package dq_pkg;

  localparam int DQ_DEPTH_DEF      = 16;
  localparam int DQ_DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- src/double_ended_queue.sv -----
// path: an accepted request moves through the pending stage to the output register
// throughput: one request per cycle while the result side takes them; the entry
//   memory reads or writes one slot per request on its single port
// reset: rst_n low clears pointers, count and both valid flags; the entry memory
//   is not cleared, and only slots that were written are ever read
// ---------------------------------------------------------------------------
// double_ended_queue
// bounded deque on a circular buffer in a one-port synchronous memory
// ---------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH_DEF,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IN_W      = ((KIND_W + DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((STATUS_W + DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // kind, value, zero pad
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, data_out, count, zero pad
);

  localparam int AW     = $clog2(DEPTH);
  localparam int OUT_FW = STATUS_W + DATA_WIDTH + CW;

  // request fields
  kind_t                 req_kind;
  logic [DATA_WIDTH-1:0] req_value;

  assign req_kind  = kind_t'(in_tdata[KIND_W-1:0]);
  assign req_value = in_tdata[KIND_W +: DATA_WIDTH];

  // pointer and count state
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // neighbor slots with wrap at DEPTH, which need not be a power of two
  logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;

  assign head_prev = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_next = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;
  assign tail_next = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  logic accept;
  assign accept = in_tvalid & in_tready;

  // request decode: memory access, status and next pointers
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  status_t       req_status;

  always_comb begin
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = tail_r;
    rd_addr    = head_r;
    req_status = ST_OK;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    unique case (req_kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (cnt_r == CW'(DEPTH)) begin
          req_status = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (req_kind == KIND_PUSH_FRONT) begin
            wr_addr  = head_prev;
            head_nxt = head_prev;
          end else begin
            wr_addr  = tail_r;
            tail_nxt = tail_next;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
        if (cnt_r == '0) begin
          req_status = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          // back end reads the slot just before the tail
          if (req_kind == KIND_POP_BACK || req_kind == KIND_PEEK_BACK) begin
            rd_addr = tail_prev;
          end else begin
            rd_addr = head_r;
          end
          if (req_kind == KIND_POP_FRONT) begin
            head_nxt = head_next;
            cnt_nxt  = cnt_r - 1'b1;
          end else if (req_kind == KIND_POP_BACK) begin
            tail_nxt = tail_prev;
            cnt_nxt  = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        // unknown kind: state unchanged, ok status, zero data
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry memory, one access per request, registered read data.
  // a write is visible to the read of any later request, so no forwarding is needed
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= req_value;
    end
    if (accept && rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // pending stage: holds status and count while the memory read data is registered
  logic          pend_r, pend_nxt;
  status_t       pend_st_r;
  logic          pend_rd_r;
  logic [CW-1:0] pend_cnt_r;
  logic          pend_move;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_st_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [CW-1:0]         out_cnt_r;

  assign pend_move = pend_r & (~out_valid_r | out_tready);
  assign in_tready = ~pend_r | pend_move;

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (pend_move) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_st_r  <= req_status;
      pend_rd_r  <= rd_en;
      pend_cnt_r <= cnt_nxt;
    end
    if (pend_move) begin
      out_st_r   <= pend_st_r;
      out_data_r <= pend_rd_r ? mem_q : '0;
      out_cnt_r  <= pend_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata             = '0;
    out_tdata[OUT_FW-1:0] = {out_cnt_r, out_data_r, out_st_r};
  end

endmodule

// ----- src/dq_checker.sv -----
// ---------------------------------------------------------------------------
// dq_checker
// port-level checks on the results of the double-ended queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH_DEF,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int OUT_W     = ((STATUS_W + DATA_WIDTH + CW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata   // status, data_out, count, zero pad
);

  logic [STATUS_W-1:0]   res_status;
  logic [DATA_WIDTH-1:0] res_data;
  logic [CW-1:0]         res_cnt;

  assign res_status = out_tdata[STATUS_W-1:0];
  assign res_data   = out_tdata[STATUS_W +: DATA_WIDTH];
  assign res_cnt    = out_tdata[STATUS_W + DATA_WIDTH +: CW];

  `DQ_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `DQ_ASSERT(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `DQ_ASSERT(a_full_count, out_tvalid && res_status == ST_FULL |-> res_cnt == CW'(DEPTH), "full status below depth")
  `DQ_ASSERT(a_empty_zero, out_tvalid && res_status == ST_EMPTY |-> res_cnt == '0 && res_data == '0, "empty result not zero")
  // request side only stalls behind a waiting result
  `DQ_ASSERT(a_stall_reason, !in_tready |-> out_tvalid && !out_tready, "request stalled with no waiting result")

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the double-ended queue: requests are driven on the
// in_* stream, a shadow deque predicts every result, and each out_* result
// is compared field by field against the oldest prediction
// ---------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  localparam int DEPTH  = DQ_DEPTH_DEF;
  localparam int DW     = DQ_DATA_WIDTH_DEF;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IN_W   = ((KIND_W + DW + 7) / 8) * 8;
  localparam int OUT_W  = ((STATUS_W + DW + CW + 7) / 8) * 8;
  localparam int IDLE_PCT   = 37;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 2000;

  // the two kind codes the block must ignore
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DW-1:0]     value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DW-1:0]       data;
    logic [CW-1:0]       count;
  } answer_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // kind, value, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // status, data_out, count, zero pad

  // stimulus waiting to be driven, predictions waiting for their result
  request_t req_backlog[$];
  answer_t  answers_due[$];

  // shadow deque
  logic [DW-1:0] shadow_word [DEPTH];
  int            shadow_head = 0;
  int            shadow_tail = 0;
  int            shadow_fill = 0;

  int err_count    = 0;
  bit req_taken    = 1'b0;   // current request was accepted at the last rising edge
  bit steady       = 1'b0;   // both sides stop idling while set
  int hold_asks    = 0;      // receiver hold-offs asked for by the stimulus
  int holds_served = 0;
  int hold_left    = 0;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // one request applied to the shadow deque, returns the result it must give
  function automatic answer_t apply_request(input logic [KIND_W-1:0] kind,
                                            input logic [DW-1:0] value);
    answer_t ans;
    int      slot;
    ans.status = ST_OK;
    ans.data   = '0;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          ans.status = ST_FULL;
        end else if (kind == KIND_PUSH_FRONT) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_word[shadow_head] = value;
          shadow_fill++;
        end else begin
          shadow_word[shadow_tail] = value;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_fill++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
        if (shadow_fill == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          // front reads the head slot, back reads the slot behind the tail
          if (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT)
            slot = shadow_head;
          else
            slot = (shadow_tail + DEPTH - 1) % DEPTH;
          ans.data = shadow_word[slot];
          if (kind == KIND_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_fill--;
          end else if (kind == KIND_POP_BACK) begin
            shadow_tail = slot;
            shadow_fill--;
          end
        end
      end
      default: ;  // spare kinds leave the deque alone
    endcase
    ans.count = CW'(shadow_fill);
    return ans;
  endfunction

  function automatic void queue_req(input logic [KIND_W-1:0] kind,
                                    input logic [DW-1:0] value);
    request_t r;
    r.kind  = kind;
    r.value = value;
    req_backlog.push_back(r);
  endfunction

  // random requests in runs with a push bias, so the deque swings between
  // empty and full again and again
  task automatic queue_random(input int n);
    int               left;
    int               run;
    int               push_pct;
    int               roll;
    logic [KIND_W-1:0] kind;
    logic [DW-1:0]    value;
    left = n;
    while (left > 0) begin
      run = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < run && left > 0; i++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          kind = ($urandom_range(1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
        end else if ($urandom_range(99) < push_pct) begin
          kind = ($urandom_range(1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else begin
          case ($urandom_range(3))
            0:       kind = KIND_POP_FRONT;
            1:       kind = KIND_POP_BACK;
            2:       kind = KIND_PEEK_FRONT;
            default: kind = KIND_PEEK_BACK;
          endcase
        end
        roll = $urandom_range(9);
        if (roll == 0)      value = '0;
        else if (roll == 1) value = '1;
        else                value = DW'($urandom);
        queue_req(kind, value);
        left--;
      end
    end
  endtask

  // sender: presents the next request on the falling edge once the previous
  // one has gone, idling at random unless steady
  always @(negedge clk) begin : drive_requests
    request_t r;
    if (rst_n && (!in_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        r = req_backlog.pop_front();
        in_tdata  <= IN_W'({r.value, r.kind});
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off counted here when
  // the stimulus asks for one
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (holds_served != hold_asks) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // accepted requests go through the shadow deque, accepted results are
  // compared with the oldest prediction
  always @(posedge clk) begin : watch_streams
    answer_t got;
    answer_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        answers_due.push_back(apply_request(in_tdata[KIND_W-1:0],
                                            in_tdata[KIND_W +: DW]));
        req_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[STATUS_W-1:0];
        got.data   = out_tdata[STATUS_W +: DW];
        got.count  = out_tdata[STATUS_W + DW +: CW];
        if (answers_due.size() == 0) begin
          report_mismatch("result with no request pending", 64'(got.data), 64'd0);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.data !== want.data)
            report_mismatch("data_out", 64'(got.data), 64'(want.data));
          if (got.count !== want.count)
            report_mismatch("count", 64'(got.count), 64'(want.count));
        end
      end
    end
  end

  // stimulus phases and end of run
  initial begin : stimulus
    int waited;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, spare kinds, extreme words, fill to full
    queue_req(KIND_PEEK_FRONT, '1);
    queue_req(KIND_PEEK_BACK, '0);
    queue_req(KIND_POP_FRONT, '1);
    queue_req(KIND_POP_BACK, '0);
    queue_req(KIND_SPARE_A, '1);
    queue_req(KIND_SPARE_B, '1);
    queue_req(KIND_PUSH_FRONT, '1);
    queue_req(KIND_PUSH_BACK, '0);
    queue_req(KIND_PEEK_FRONT, '0);
    queue_req(KIND_PEEK_BACK, '1);
    queue_req(KIND_POP_FRONT, '0);
    queue_req(KIND_POP_BACK, '0);
    // the head pointer wraps on the way to full
    for (int i = 0; i < DEPTH; i++)
      queue_req((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                (i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555);
    queue_req(KIND_PUSH_FRONT, '1);
    queue_req(KIND_PUSH_BACK, '1);

    // random with idling on both sides
    queue_random(500);
    while (req_backlog.size() != 0) @(posedge clk);

    // long stretch with no idling
    steady = 1'b1;
    queue_random(400);
    while (req_backlog.size() != 0) @(posedge clk);
    steady = 1'b0;

    // receiver holds off while the sender keeps offering requests
    hold_asks++;
    queue_random(60);
    while (req_backlog.size() != 0) @(posedge clk);

    queue_random(440);
    while (req_backlog.size() != 0 || in_tvalid) @(posedge clk);

    waited = 0;
    while (answers_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (answers_due.size() != 0)
      report_mismatch("results never arrived", 64'(answers_due.size()), 64'd0);
    // then wait on to catch stray results
    repeat (4) @(posedge clk);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/dq_pkg.sv
src/double_ended_queue.sv
src/dq_checker.sv
verif/tb_top.sv
